@@ rtl/core/dva_pkg.sv @@
// Shared constants, types and calendar helper functions for the date add block.
`timescale 1ns / 1ps

package dva_pkg;

    // Width of the day counter; only the low COUNT_BITS bits of days_to_add are used
    localparam int COUNT_BITS = 16;

    localparam logic [13:0] YEAR_MAX       = 14'd16383;
    localparam logic [13:0] BASE_YEAR_INIT = 14'd1601;
    localparam logic [4:0]  LAST_DAY_DEC   = 5'd31;
    localparam logic [3:0]  MONTH_JAN      = 4'd1;
    localparam logic [3:0]  MONTH_FEB      = 4'd2;
    localparam logic [3:0]  MONTH_APR      = 4'd4;
    localparam logic [3:0]  MONTH_JUN      = 4'd6;
    localparam logic [3:0]  MONTH_SEP      = 4'd9;
    localparam logic [3:0]  MONTH_NOV      = 4'd11;
    localparam logic [3:0]  MONTH_DEC      = 4'd12;

    // Reciprocal of 100 scaled by 2^19; exact quotient for any 14-bit year
    localparam logic [26:0] RECIP_100     = 27'd5243;
    localparam int          RECIP_SHIFT   = 19;
    // Fraction bits stay below this bound exactly when the year is a multiple of 100
    localparam logic [18:0] FRAC_LIMIT    = 19'd2048;

    typedef logic [COUNT_BITS-1:0] count_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic check;
        logic step;
    } dva_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic date_ok;
        logic step_done;
    } dva_status_t;

    // Gregorian leap rule: by 400, or by 4 and not by 100
    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic        by_100;
        logic [7:0]  cent;
        begin
            prod   = 27'(y) * RECIP_100;
            by_100 = (prod[RECIP_SHIFT-1:0] < FRAC_LIMIT);
            cent   = prod[26:RECIP_SHIFT];
            is_leap = (y[1:0] == 2'd0) && (!by_100 || (cent[1:0] == 2'd0));
        end
    endfunction

    // Length of month m; leap selects 29 days for February
    function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            case (m)
                MONTH_FEB: len = leap ? 5'd29 : 5'd28;
                MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
                default: len = 5'd31;
            endcase
            days_in = len;
        end
    endfunction

endpackage

@@ rtl/core/dva_datapath.sv @@
// Datapath: date registers, day counter, leap flag and the month step unit.
`timescale 1ns / 1ps

module dva_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                base_year_we,
    input  logic [13:0]         base_year_wdata,
    input  logic [4:0]          day,
    input  logic [3:0]          month,
    input  logic [13:0]         year,
    input  logic [15:0]         days_to_add,
    input  dva_pkg::dva_cmd_t   cmd,
    output dva_pkg::dva_status_t status,
    output logic                date_valid,
    output logic                overflow,
    output logic [4:0]          result_day,
    output logic [3:0]          result_month,
    output logic [13:0]         result_year
);

    logic [13:0]      base_year_reg;
    logic [4:0]       day_reg, day_next;
    logic [3:0]       month_reg, month_next;
    logic [13:0]      year_reg, year_next;
    dva_pkg::count_t  count_reg, count_next;
    logic             leap_reg;
    logic             valid_reg, valid_next;
    logic             ovf_reg, ovf_next;

    logic [4:0]       dim;
    logic [4:0]       room;
    logic [5:0]       room_inc;
    logic             fits;
    logic             year_end;

    // Hold the base year register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_year_reg <= dva_pkg::BASE_YEAR_INIT;
        end
        else if (base_year_we)
        begin
            base_year_reg <= base_year_wdata;
        end
    end

    // Month length and remaining room in the current month
    assign dim      = dva_pkg::days_in(month_reg, leap_reg);
    assign room     = dim - day_reg;
    assign room_inc = {1'b0, room} + 6'd1;
    assign fits     = (count_reg <= dva_pkg::count_t'(room));
    assign year_end = (month_reg == dva_pkg::MONTH_DEC) && (year_reg == dva_pkg::YEAR_MAX);

    // Validity of the loaded date
    assign status.date_ok = (year_reg >= base_year_reg)
                         && (month_reg inside {[dva_pkg::MONTH_JAN:dva_pkg::MONTH_DEC]})
                         && (day_reg != 5'd0)
                         && (day_reg <= dim);

    // Stepping ends when the count fits or the year range runs out
    assign status.step_done = fits || year_end;

    // Load, check, or step: add the count within the month, saturate at the top year, or advance one month
    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        count_next = count_reg;
        valid_next = valid_reg;
        ovf_next   = ovf_reg;
        if (cmd.load)
        begin
            day_next   = day;
            month_next = month;
            year_next  = year;
            count_next = dva_pkg::count_t'(days_to_add);
            valid_next = 1'b0;
            ovf_next   = 1'b0;
        end
        else if (cmd.check)
        begin
            valid_next = status.date_ok;
        end
        else if (cmd.step)
        begin
            if (fits)
            begin
                day_next = day_reg + count_reg[4:0];
            end
            else if (year_end)
            begin
                // Saturate at the last day of the top year
                day_next   = dva_pkg::LAST_DAY_DEC;
                month_next = dva_pkg::MONTH_DEC;
                year_next  = dva_pkg::YEAR_MAX;
                ovf_next   = 1'b1;
            end
            else
            begin
                count_next = count_reg - dva_pkg::count_t'(room_inc);
                day_next   = 5'd1;
                if (month_reg == dva_pkg::MONTH_DEC)
                begin
                    month_next = dva_pkg::MONTH_JAN;
                    year_next  = year_reg + 14'd1;
                end
                else
                begin
                    month_next = month_reg + 4'd1;
                end
            end
        end
    end

    // Hold the payload registers
    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        count_reg <= count_next;
        // Leap flag is registered from year_reg, so it trails a year change; January never needs it
        leap_reg  <= dva_pkg::is_leap(year_reg);
    end

    // Hold the result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign date_valid   = valid_reg;
    assign overflow     = ovf_reg;
    assign result_day   = day_reg;
    assign result_month = month_reg;
    assign result_year  = year_reg;

    // Overflow only ever comes with a saturated date
    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (day_reg == dva_pkg::LAST_DAY_DEC) && (month_reg == dva_pkg::MONTH_DEC)
                    && (year_reg == dva_pkg::YEAR_MAX))
        else $error("overflow set without saturated date");

    // Overflow implies a valid start date
    a_ovf_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> valid_reg)
        else $error("overflow set on invalid date");

    // Date holds when no command moves it
    a_date_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.load && !cmd.step) |=> $stable(year_reg) && $stable(month_reg))
        else $error("date changed without a command");

endmodule

@@ rtl/core/dva_ctrl.sv @@
// Controller: state machine that sequences load, check and month steps.
`timescale 1ns / 1ps

module dva_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  dva_pkg::dva_status_t status,
    output dva_pkg::dva_cmd_t    cmd,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PREP  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_STEP  = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // Advance the state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_PREP;
            ST_PREP:  state_next = ST_CHECK;
            ST_CHECK: state_next = status.date_ok ? ST_STEP : ST_DONE;
            ST_STEP:  if (status.step_done) state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Drive datapath commands
    assign cmd.load  = (state_reg == ST_IDLE) && start;
    assign cmd.check = (state_reg == ST_CHECK);
    assign cmd.step  = (state_reg == ST_STEP);

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    // Result beat lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // Accepted start makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy && !done)
        else $error("start not taken");

    // Stepping continues until the datapath reports completion
    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !status.step_done) |=> cmd.step)
        else $error("stepping stopped early");

endmodule

@@ rtl/core/date_validate_add_days.sv @@
// An accepted start passes through the prepare and check states; an invalid date then
// goes to done, while a valid one runs month steps until the count fits or the top year runs out.
// The month step unit advances one calendar month per cycle; a final step sets the day.
// Throughput: one item at a time; start is taken again the cycle after done.
// Reset (rst_n low, asynchronous) returns to idle and sets base_year to 1601.
// Results are shown for one cycle with done; the receiver cannot stall.
`timescale 1ns / 1ps

module date_validate_add_days (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        base_year_we,
    input  logic [13:0] base_year_wdata,
    input  logic [4:0]  day,
    input  logic [3:0]  month,
    input  logic [13:0] year,
    input  logic [15:0] days_to_add,
    output logic        done,
    output logic        date_valid,
    output logic        overflow,
    output logic [4:0]  result_day,
    output logic [3:0]  result_month,
    output logic [13:0] result_year
);

    dva_pkg::dva_cmd_t    cmd;
    dva_pkg::dva_status_t status;

    // Sequence the beat through check and month steps
    dva_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold the date and do the arithmetic
    dva_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .base_year_we    (base_year_we),
        .base_year_wdata (base_year_wdata),
        .day             (day),
        .month           (month),
        .year            (year),
        .days_to_add     (days_to_add),
        .cmd             (cmd),
        .status          (status),
        .date_valid      (date_valid),
        .overflow        (overflow),
        .result_day      (result_day),
        .result_month    (result_month),
        .result_year     (result_year)
    );

endmodule

@@ verif/date_add_checker.sv @@
// Checker for the date add block: predicts each result from the accepted beats and compares.
`timescale 1ns / 1ps

module date_add_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        base_year_we,
    input  logic [13:0] base_year_wdata,
    input  logic [4:0]  day,
    input  logic [3:0]  month,
    input  logic [13:0] year,
    input  logic [15:0] days_to_add,
    input  logic        done,
    input  logic        date_valid,
    input  logic        overflow,
    input  logic [4:0]  result_day,
    input  logic [3:0]  result_month,
    input  logic [13:0] result_year,
    output int          error_count,
    output int          outstanding,
    output int          valid_seen,
    output int          overflow_seen
);

    typedef struct packed {
        logic        valid;
        logic        ovf;
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
    } date_result_t;

    date_result_t due_dates[$];
    logic [13:0]  floor_year = dva_pkg::BASE_YEAR_INIT;
    int           errs = 0;
    int           valid_n = 0;
    int           ovf_n = 0;

    // Gregorian rule: every 400th year, else every 4th that is not a century
    function automatic bit leap_rule(input int unsigned yr);
        return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    endfunction

    function automatic int unsigned month_length(input int unsigned mo, input int unsigned yr);
        int unsigned len;
        begin
            case (mo)
                dva_pkg::MONTH_FEB: len = leap_rule(yr) ? 29 : 28;
                dva_pkg::MONTH_APR, dva_pkg::MONTH_JUN,
                dva_pkg::MONTH_SEP, dva_pkg::MONTH_NOV: len = 30;
                default: len = 31;
            endcase
            return len;
        end
    endfunction

    // Validate the start date, then walk month by month until the count is used up
    function automatic date_result_t add_days(input logic [4:0] d, input logic [3:0] m,
                                              input logic [13:0] y, input logic [15:0] n,
                                              input logic [13:0] floor_y);
        date_result_t r;
        int unsigned  dd;
        int unsigned  mm;
        int unsigned  yy;
        int unsigned  left;
        int unsigned  room;
        bit           settled;
        begin
            dd      = d;
            mm      = m;
            yy      = y;
            left    = n[dva_pkg::COUNT_BITS-1:0];
            r.valid = 1'b0;
            r.ovf   = 1'b0;
            settled = 1'b0;
            if (yy >= floor_y && mm >= dva_pkg::MONTH_JAN && mm <= dva_pkg::MONTH_DEC
                && dd >= 1 && dd <= month_length(mm, yy))
            begin
                r.valid = 1'b1;
                while (!settled)
                begin
                    room = month_length(mm, yy) - dd;
                    if (left <= room)
                    begin
                        dd      = dd + left;
                        settled = 1'b1;
                    end
                    else
                    begin
                        left = left - (room + 1);
                        dd   = 1;
                        mm   = mm + 1;
                        if (mm > dva_pkg::MONTH_DEC)
                        begin
                            mm = dva_pkg::MONTH_JAN;
                            yy = yy + 1;
                            // saturate at the last day of the top year
                            if (yy > dva_pkg::YEAR_MAX)
                            begin
                                r.ovf   = 1'b1;
                                dd      = dva_pkg::LAST_DAY_DEC;
                                mm      = dva_pkg::MONTH_DEC;
                                yy      = dva_pkg::YEAR_MAX;
                                settled = 1'b1;
                            end
                        end
                    end
                end
            end
            r.d = dd[4:0];
            r.m = mm[3:0];
            r.y = yy[13:0];
            return r;
        end
    endfunction

    // Track the floor register, queue predictions, and check each done beat
    always @(posedge clk or negedge rst_n)
    begin : watch
        date_result_t want;
        date_result_t got;
        bit           bad;
        if (!rst_n)
        begin
            floor_year = dva_pkg::BASE_YEAR_INIT;
            due_dates.delete();
        end
        else
        begin
            if (base_year_we)
                floor_year = base_year_wdata;
            if (start && !busy)
                due_dates.push_back(add_days(day, month, year, days_to_add, floor_year));
            if (done)
            begin
                got.valid = date_valid;
                got.ovf   = overflow;
                got.d     = result_day;
                got.m     = result_month;
                got.y     = result_year;
                if (got.valid === 1'b1)
                    valid_n++;
                if (got.ovf === 1'b1)
                    ovf_n++;
                if (due_dates.size() == 0)
                begin
                    errs++;
                    if (errs <= 10)
                        $display("[%0t] result beat with nothing pending: %0d/%0d/%0d",
                                 $time, got.d, got.m, got.y);
                end
                else
                begin
                    want = due_dates.pop_front();
                    bad  = (got.valid !== want.valid) || (got.ovf !== want.ovf)
                        || (got.d !== want.d) || (got.m !== want.m) || (got.y !== want.y);
                    if (bad)
                    begin
                        errs++;
                        if (errs <= 10)
                        begin
                            $display("[%0t] date mismatch: expected valid=%0b ovf=%0b %0d/%0d/%0d",
                                     $time, want.valid, want.ovf, want.d, want.m, want.y);
                            $display("    actual valid=%0b ovf=%0b %0d/%0d/%0d",
                                     got.valid, got.ovf, got.d, got.m, got.y);
                        end
                    end
                end
            end
        end
        error_count   <= errs;
        outstanding   <= due_dates.size();
        valid_seen    <= valid_n;
        overflow_seen <= ovf_n;
    end

endmodule

@@ verif/tb_top.sv @@
// Top of the date add testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int          PHASES      = 6;
    localparam int          PHASE_ITEMS = 42;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        base_year_we;
    logic [13:0] base_year_wdata;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [15:0] days_to_add;
    logic        done;
    logic        date_valid;
    logic        overflow;
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;

    int          error_count;
    int          outstanding;
    int          valid_seen;
    int          overflow_seen;
    int unsigned sent;
    int unsigned idle_cycles;
    logic [13:0] floor_now;
    bit          no_gaps;

    date_validate_add_days dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .base_year_we    (base_year_we),
        .base_year_wdata (base_year_wdata),
        .day             (day),
        .month           (month),
        .year            (year),
        .days_to_add     (days_to_add),
        .done            (done),
        .date_valid      (date_valid),
        .overflow        (overflow),
        .result_day      (result_day),
        .result_month    (result_month),
        .result_year     (result_year)
    );

    date_add_checker u_date_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .base_year_we    (base_year_we),
        .base_year_wdata (base_year_wdata),
        .day             (day),
        .month           (month),
        .year            (year),
        .days_to_add     (days_to_add),
        .done            (done),
        .date_valid      (date_valid),
        .overflow        (overflow),
        .result_day      (result_day),
        .result_month    (result_month),
        .result_year     (result_year),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .valid_seen      (valid_seen),
        .overflow_seen   (overflow_seen)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // End the run if no beat moves for too long
    initial
    begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || base_year_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Mostly short gaps, a few long ones, none during a burst
    function automatic int unsigned pick_gap();
        int unsigned r;
        begin
            r = $urandom_range(0, 99);
            if (no_gaps || r < 50)
                return 0;
            if (r < 88)
                return $urandom_range(1, 3);
            if (r < 97)
                return $urandom_range(4, 12);
            return $urandom_range(30, 90);
        end
    endfunction

    // Keep most counts small so runs stay short; full range and extremes now and then
    function automatic logic [15:0] pick_count();
        int unsigned r;
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
                return 16'($urandom_range(0, 40));
            if (r < 50)
                return 16'($urandom_range(41, 800));
            if (r < 60)
                return (r < 55) ? 16'hFFFF : 16'h0000;
            if (r < 75)
                return 16'($urandom_range(800, 6000));
            return 16'($urandom);
        end
    endfunction

    // Drive one date beat and hold start until it is taken
    task automatic send_date(input logic [4:0] d, input logic [3:0] m,
                             input logic [13:0] y, input logic [15:0] n);
        int unsigned gap;
        begin
            day         <= d;
            month       <= m;
            year        <= y;
            days_to_add <= n;
            start       <= 1'b1;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            sent++;
            gap = pick_gap();
            if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Mostly well-formed dates at or above the floor, the rest raw noise
    task automatic send_random();
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
        int unsigned span;
        begin
            if ($urandom_range(0, 99) < 80)
            begin
                span = 32'(dva_pkg::YEAR_MAX - floor_now);
                case ($urandom_range(0, 3))
                    0: y = 14'(dva_pkg::YEAR_MAX - $urandom_range(0, span < 150 ? span : 150));
                    1: y = 14'(floor_now + $urandom_range(0, span < 150 ? span : 150));
                    default: y = 14'(floor_now + $urandom_range(0, span));
                endcase
                m = 4'($urandom_range(dva_pkg::MONTH_JAN, dva_pkg::MONTH_DEC));
                d = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(29, 31))
                                                : 5'($urandom_range(1, 28));
            end
            else
            begin
                d = 5'($urandom);
                m = 4'($urandom);
                y = 14'($urandom);
            end
            send_date(d, m, y, pick_count());
        end
    endtask

    // Drop start and wait until every pending result has come back
    task automatic settle();
        begin
            start <= 1'b0;
            @(posedge clk);
            while (outstanding != 0 || busy)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    // Write the floor register; only called while the block is idle
    task automatic set_base_year(input logic [13:0] v);
        begin
            base_year_we    <= 1'b1;
            base_year_wdata <= v;
            @(posedge clk);
            base_year_we    <= 1'b0;
            floor_now = v;
        end
    endtask

    initial
    begin : stimulus
        int ph;
        int k;
        rst_n           = 1'b0;
        start           = 1'b0;
        base_year_we    = 1'b0;
        base_year_wdata = '0;
        day             = '0;
        month           = '0;
        year            = '0;
        days_to_add     = '0;
        sent            = 0;
        floor_now       = dva_pkg::BASE_YEAR_INIT;
        no_gaps         = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed dates at the reset floor
        send_date(5'd1, dva_pkg::MONTH_JAN, 14'd1601, 16'd0);       // floor year, zero count
        send_date(5'd31, dva_pkg::MONTH_DEC, 14'd1600, 16'd5);      // one below the floor
        send_date(5'd29, dva_pkg::MONTH_FEB, 14'd2000, 16'd1);      // leap by 400
        send_date(5'd29, dva_pkg::MONTH_FEB, 14'd1900, 16'd0);      // century, not leap
        send_date(5'd29, dva_pkg::MONTH_FEB, 14'd2024, 16'd365);
        send_date(5'd29, dva_pkg::MONTH_FEB, 14'd2023, 16'd3);      // not leap
        send_date(5'd31, 4'd5, 14'd2023, 16'd1);                    // May has 31 days
        send_date(5'd31, dva_pkg::MONTH_APR, 14'd2023, 16'd1);      // day past month end
        send_date(5'd0, dva_pkg::MONTH_JUN, 14'd2023, 16'd7);       // day zero
        send_date(5'd15, 4'd0, 14'd2023, 16'd7);                    // month zero
        send_date(5'd15, 4'd13, 14'd2023, 16'd7);                   // month past December
        send_date(5'd31, 4'd15, 14'd16383, 16'hFFFF);               // all fields at top
        send_date(5'd0, 4'd0, 14'd0, 16'd0);                        // all fields zero
        send_date(5'd31, dva_pkg::MONTH_DEC, 14'd16383, 16'd1);     // overflow by one day
        send_date(5'd31, dva_pkg::MONTH_DEC, 14'd16383, 16'd0);
        send_date(5'd1, dva_pkg::MONTH_JAN, 14'd16383, 16'hFFFF);   // overflow, largest count
        send_date(5'd1, dva_pkg::MONTH_JAN, 14'd1601, 16'hFFFF);    // largest count
        send_date(5'd28, dva_pkg::MONTH_FEB, 14'd2100, 16'd1);
        send_date(5'd30, dva_pkg::MONTH_NOV, 14'd1999, 16'd32);     // year rollover
        send_date(5'd10, dva_pkg::MONTH_SEP, 14'd2345, 16'h5555);
        settle();

        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_base_year(14'd0);
                1: set_base_year(14'd16383);
                2: set_base_year(dva_pkg::BASE_YEAR_INIT);
                4: set_base_year(14'd2000);
                default: set_base_year(14'($urandom_range(0, 16383)));
            endcase
            if (ph == 0)
            begin
                send_date(5'd29, dva_pkg::MONTH_FEB, 14'd0, 16'd1);     // year zero is leap
                send_date(5'd17, dva_pkg::MONTH_JUN, 14'd0, 16'hAAAA);
            end
            if (ph == 1)
            begin
                send_date(5'd1, dva_pkg::MONTH_JAN, 14'd16383, 16'd364);
                send_date(5'd1, dva_pkg::MONTH_JAN, 14'd16383, 16'd365);
                send_date(5'd31, dva_pkg::MONTH_DEC, 14'd16382, 16'd0);
            end
            no_gaps = (ph == 2) || ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // hold off mid-phase until the block has drained
                if (k == PHASE_ITEMS / 2)
                    settle();
                send_random();
            end
            settle();
        end
        repeat (20) @(posedge clk);

        $display("Run covered %0d dates over %0d floor-year settings, both extremes included.",
                 sent, PHASES + 1);
        $display("Results: %0d valid, %0d saturated at the top year, %0d failures.",
                 valid_seen, overflow_seen, error_count);
        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
